### src/assert_macros.svh
// Assertion macros shared by the echo ranging RTL.
// Every macro samples on aclk and is disabled while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain invariant.
`define ERMA_ASSERT(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error(msg);

// Same-cycle implication.
`define ERMA_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ERMA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/erma_pkg.sv
// Shared types and constants for the echo ranging moving-average block.
// No dependencies; used by erma_front, erma_fifo, erma_back and the top level.
`timescale 1ns / 1ps

package erma_pkg;

    localparam int CH_W      = 2;
    localparam int TIME_W    = 32;
    localparam int DIST_W    = 8;
    localparam int TIMEOUT_W = 20;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 20'd30000;

    // A non-timeout pulse is shorter than the 20-bit timeout, so 20 bits of length suffice.
    localparam int LEN_W = TIMEOUT_W;

    // length / 58 as (length * ceil(2^26 / 58)) >> 26, exact for lengths below 2^20
    localparam int CM_SHIFT   = 26;
    localparam int CM_RECIP_W = 21;
    localparam logic [CM_RECIP_W-1:0] CM_RECIP = 21'd1157050;

    localparam logic EDGE_RISING  = 1'b0;
    localparam logic EDGE_FALLING = 1'b1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // One falling edge waiting for the back end
    typedef struct packed {
        logic [CH_W-1:0]  channel;
        logic             timed_out;
        logic [LEN_W-1:0] length;
    } echo_entry_t;

endpackage

### src/erma_fifo.sv
// Short queue of classified echo words between front and back end.
// Depends on erma_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module erma_fifo (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  erma_pkg::echo_entry_t in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output erma_pkg::echo_entry_t out_data
);

    localparam int CNT_W = erma_pkg::QPTR_W + 1;

    erma_pkg::echo_entry_t     entry_reg [erma_pkg::QUEUE_DEPTH];
    logic [erma_pkg::QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic                        push, pop;

    assign in_ready  = (count_reg != CNT_W'(erma_pkg::QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_data;
        end
    end

    `ERMA_ASSERT(a_count_bound, count_reg <= CNT_W'(erma_pkg::QUEUE_DEPTH), "queue count overflow")
    `ERMA_ASSERT_NEXT(a_count_push, push && !pop, count_reg == $past(count_reg) + 1'b1, "push lost")

endmodule

### src/erma_front.sv
// Front end: timeout register, per-channel start stamps, edge classification.
// Falling edges go to the queue with their pulse length and timeout flag.
// Depends on erma_pkg.
`timescale 1ns / 1ps

module erma_front #(
    parameter int CHANNELS = 3
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [erma_pkg::TIMEOUT_W-1:0]    cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [erma_pkg::CH_W-1:0]         s_channel,
    input  logic                              s_edge_kind,
    input  logic [erma_pkg::TIME_W-1:0]       s_time_us,
    output logic                              q_valid,
    input  logic                              q_ready,
    output erma_pkg::echo_entry_t             q_data
);

    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [erma_pkg::TIMEOUT_W-1:0] timeout_reg;
    logic [erma_pkg::TIME_W-1:0]    stamp_reg [CHANNELS];
    logic [CH_IDX_W-1:0]            ch_idx;
    logic                           ch_ok, accept, timed_out;
    logic [erma_pkg::TIME_W-1:0]    length;

    assign cfg_ready = 1'b1;
    assign s_ready   = q_ready;
    assign accept    = s_valid && s_ready;
    assign ch_idx    = CH_IDX_W'(s_channel);
    assign ch_ok     = (32'(s_channel) < 32'(CHANNELS));

    // modulo 2^32 pulse length
    assign length    = s_time_us - stamp_reg[ch_idx];
    assign timed_out = (length >= erma_pkg::TIME_W'(timeout_reg));

    assign q_valid = accept && ch_ok && (s_edge_kind == erma_pkg::EDGE_FALLING);
    always_comb begin
        q_data.channel   = s_channel;
        q_data.timed_out = timed_out;
        q_data.length    = length[erma_pkg::LEN_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= erma_pkg::TIMEOUT_RESET;
            for (int i = 0; i < CHANNELS; i++) begin
                stamp_reg[i] <= '0;
            end
        end else begin
            if (cfg_valid) begin
                timeout_reg <= cfg_data;
            end
            if (accept && ch_ok && (s_edge_kind == erma_pkg::EDGE_RISING)) begin
                stamp_reg[ch_idx] <= s_time_us;
            end
        end
    end

endmodule

### src/erma_back.sv
// Back end: cm conversion, per-channel sample window read-modify-write, average.
// Stages: pop (multiply, window read), update (state + window write), average, output.
// Depends on erma_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module erma_back #(
    parameter int CHANNELS    = 3,
    parameter int WINDOW_SIZE = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    output logic                          q_ready,
    input  erma_pkg::echo_entry_t         q_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [erma_pkg::CH_W-1:0]     m_out_channel,
    output logic [erma_pkg::DIST_W-1:0]   m_distance_cm,
    output logic [erma_pkg::DIST_W-1:0]   m_average_cm,
    output logic                          m_average_valid,
    output logic                          m_timed_out
);

    localparam int CH_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int WIN_IDX_W = $clog2(WINDOW_SIZE);
    localparam int FILL_W    = $clog2(WINDOW_SIZE + 1);
    localparam int SUM_W     = erma_pkg::DIST_W + $clog2(WINDOW_SIZE);
    localparam int ADDR_W    = CH_IDX_W + WIN_IDX_W;
    localparam int MEM_DEPTH = 1 << ADDR_W;
    localparam int PROD_W    = erma_pkg::LEN_W + erma_pkg::CM_RECIP_W;
    // sum / WINDOW_SIZE by reciprocal; exact since sum * error < 2^AVG_SHIFT
    localparam int AVG_SHIFT = SUM_W + 8;
    localparam int RECIP_W   = AVG_SHIFT;
    localparam int APROD_W   = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] AVG_RECIP =
        RECIP_W'(((64'd1 << AVG_SHIFT) + 64'(WINDOW_SIZE) - 64'd1) / 64'(WINDOW_SIZE));
    localparam logic [FILL_W-1:0]    FILL_FULL = FILL_W'(WINDOW_SIZE);
    localparam logic [WIN_IDX_W-1:0] PTR_LAST  = WIN_IDX_W'(WINDOW_SIZE - 1);

    // per-channel window state
    logic [FILL_W-1:0]          fill_reg  [CHANNELS];
    logic [WIN_IDX_W-1:0]       ptr_reg   [CHANNELS];
    logic [SUM_W-1:0]           total_reg [CHANNELS];
    logic [erma_pkg::DIST_W-1:0] held_reg [CHANNELS];
    logic [erma_pkg::DIST_W-1:0] window_mem [MEM_DEPTH];

    // pop
    logic                  pop, pop_full;
    logic [CH_IDX_W-1:0]   pop_idx;
    logic [WIN_IDX_W-1:0]  pop_slot;

    // update stage
    logic                        s1_valid_reg, s1_tout_reg, s1_full_reg, s1_adv;
    logic [erma_pkg::CH_W-1:0]   s1_ch_reg;
    logic [PROD_W-1:0]           s1_prod_reg;
    logic [ADDR_W-1:0]           s1_addr_reg;
    logic [erma_pkg::DIST_W-1:0] s1_old_reg, s1_dist;
    logic [CH_IDX_W-1:0]         s1_idx;
    logic [SUM_W-1:0]            s1_total_next;
    logic [WIN_IDX_W-1:0]        s1_ptr_next;

    // average stage
    logic                        s2_valid_reg, s2_tout_reg, s2_avg_valid_reg, s2_adv, s2_free;
    logic [erma_pkg::CH_W-1:0]   s2_ch_reg;
    logic [erma_pkg::DIST_W-1:0] s2_dist_reg, s2_avg;
    logic [SUM_W-1:0]            s2_total_reg;
    logic [APROD_W-1:0]          s2_prod;
    logic [CH_IDX_W-1:0]         s2_idx;

    // output register
    logic                        m_valid_reg, m_avg_valid_reg, m_tout_reg, out_free;
    logic [erma_pkg::CH_W-1:0]   m_ch_reg;
    logic [erma_pkg::DIST_W-1:0] m_dist_reg, m_avg_reg;

    // one word in the read-modify-write at a time
    assign q_ready  = !s1_valid_reg;
    assign pop      = q_valid && q_ready;
    assign pop_idx  = CH_IDX_W'(q_data.channel);
    assign pop_full = (fill_reg[pop_idx] == FILL_FULL);
    assign pop_slot = pop_full ? ptr_reg[pop_idx] : fill_reg[pop_idx][WIN_IDX_W-1:0];

    assign out_free = !m_valid_reg || m_ready;
    assign s2_adv   = s2_valid_reg && out_free;
    assign s2_free  = !s2_valid_reg || s2_adv;
    assign s1_adv   = s1_valid_reg && s2_free;

    assign s1_dist = s1_prod_reg[erma_pkg::CM_SHIFT +: erma_pkg::DIST_W];
    assign s1_idx  = s1_addr_reg[ADDR_W-1 -: CH_IDX_W];

    always_comb begin
        if (s1_full_reg) begin
            s1_total_next = total_reg[s1_idx] - SUM_W'(s1_old_reg) + SUM_W'(s1_dist);
            s1_ptr_next   = (ptr_reg[s1_idx] == PTR_LAST) ? '0 : ptr_reg[s1_idx] + 1'b1;
        end else begin
            s1_total_next = total_reg[s1_idx] + SUM_W'(s1_dist);
            s1_ptr_next   = '0;
        end
    end

    assign s2_idx  = CH_IDX_W'(s2_ch_reg);
    assign s2_prod = APROD_W'(s2_total_reg) * APROD_W'(AVG_RECIP);

    always_comb begin
        if (s2_tout_reg) begin
            s2_avg = '0;
        end else if (s2_avg_valid_reg) begin
            s2_avg = s2_prod[AVG_SHIFT +: erma_pkg::DIST_W];
        end else begin
            s2_avg = held_reg[s2_idx];
        end
    end

    // control and per-channel state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                fill_reg[i]  <= '0;
                ptr_reg[i]   <= '0;
                total_reg[i] <= '0;
                held_reg[i]  <= '0;
            end
        end else begin
            if (pop) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_adv) begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv) begin
                s2_valid_reg <= 1'b1;
                if (!s1_tout_reg) begin
                    if (!s1_full_reg) begin
                        fill_reg[s1_idx] <= fill_reg[s1_idx] + 1'b1;
                    end
                    ptr_reg[s1_idx]   <= s1_ptr_next;
                    total_reg[s1_idx] <= s1_total_next;
                end
            end else if (s2_adv) begin
                s2_valid_reg <= 1'b0;
            end

            if (s2_adv) begin
                m_valid_reg      <= 1'b1;
                held_reg[s2_idx] <= s2_avg;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (pop) begin
            s1_ch_reg   <= q_data.channel;
            s1_tout_reg <= q_data.timed_out;
            s1_full_reg <= pop_full;
            s1_addr_reg <= {pop_idx, pop_slot};
            s1_prod_reg <= PROD_W'(q_data.length) * PROD_W'(erma_pkg::CM_RECIP);
        end
        if (s1_adv) begin
            s2_ch_reg        <= s1_ch_reg;
            s2_tout_reg      <= s1_tout_reg;
            s2_avg_valid_reg <= !s1_tout_reg && s1_full_reg;
            s2_dist_reg      <= s1_tout_reg ? '0 : s1_dist;
            s2_total_reg     <= s1_total_next;
        end
        if (s2_adv) begin
            m_ch_reg        <= s2_ch_reg;
            m_dist_reg      <= s2_dist_reg;
            m_avg_reg       <= s2_avg;
            m_avg_valid_reg <= s2_avg_valid_reg;
            m_tout_reg      <= s2_tout_reg;
        end
    end

    // sample window memory
    always_ff @(posedge aclk) begin
        if (pop) begin
            s1_old_reg <= window_mem[{pop_idx, pop_slot}];
        end
        if (s1_adv && !s1_tout_reg) begin
            window_mem[s1_addr_reg] <= s1_dist;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_out_channel   = m_ch_reg;
    assign m_distance_cm   = m_dist_reg;
    assign m_average_cm    = m_avg_reg;
    assign m_average_valid = m_avg_valid_reg;
    assign m_timed_out     = m_tout_reg;

    `ERMA_ASSERT_IMPL(a_tout_zero, m_valid_reg && m_tout_reg, (m_dist_reg == '0) && (m_avg_reg == '0) && !m_avg_valid_reg, "timeout word carries data")
    `ERMA_ASSERT_NEXT(a_s1_to_s2, s1_adv, s2_valid_reg, "update stage word lost")
    `ERMA_ASSERT_IMPL(a_fill_slot, s1_valid_reg && !s1_tout_reg && !s1_full_reg, s1_addr_reg[WIN_IDX_W-1:0] == fill_reg[s1_idx][WIN_IDX_W-1:0], "fill slot changed in flight")

endmodule

### src/echo_ranging_moving_average.sv
// Ultrasonic echo ranging with a per-channel moving average. Echo edge words
// (channel, edge kind, microsecond stamp) are accepted one per cycle while the
// four-word queue has room; rising edges only record the start stamp. Each falling
// edge yields one result: distance = pulse length / 58 cm, plus the windowed
// average, or a timed-out result when the pulse reaches cfg_data microseconds
// (reset 30000). The back end takes a new falling edge only once the previous one
// has left its window read-modify-write. Results pass the queue, update stage,
// average stage and output register. Channels at or above CHANNELS are dropped
// silently. Depends on erma_pkg, erma_front, erma_fifo, erma_back.
`timescale 1ns / 1ps

module echo_ranging_moving_average #(
    parameter int CHANNELS    = 3,
    parameter int WINDOW_SIZE = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [erma_pkg::TIMEOUT_W-1:0]  cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [erma_pkg::CH_W-1:0]       s_channel,
    input  logic                            s_edge_kind,
    input  logic [erma_pkg::TIME_W-1:0]     s_time_us,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [erma_pkg::CH_W-1:0]       m_out_channel,
    output logic [erma_pkg::DIST_W-1:0]     m_distance_cm,
    output logic [erma_pkg::DIST_W-1:0]     m_average_cm,
    output logic                            m_average_valid,
    output logic                            m_timed_out
);

    logic                  fq_valid, fq_ready, bq_valid, bq_ready;
    erma_pkg::echo_entry_t fq_data, bq_data;

    erma_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_channel   (s_channel),
        .s_edge_kind (s_edge_kind),
        .s_time_us   (s_time_us),
        .q_valid     (fq_valid),
        .q_ready     (fq_ready),
        .q_data      (fq_data)
    );

    erma_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_data),
        .out_valid (bq_valid),
        .out_ready (bq_ready),
        .out_data  (bq_data)
    );

    erma_back #(
        .CHANNELS    (CHANNELS),
        .WINDOW_SIZE (WINDOW_SIZE)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_valid         (bq_valid),
        .q_ready         (bq_ready),
        .q_data          (bq_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_channel   (m_out_channel),
        .m_distance_cm   (m_distance_cm),
        .m_average_cm    (m_average_cm),
        .m_average_valid (m_average_valid),
        .m_timed_out     (m_timed_out)
    );

endmodule

### verif/echo_ranging_moving_average_tb.sv
// Testbench for echo_ranging_moving_average: directed and random echo edge words,
// with a scoreboard that predicts each range result and checks it field by field.
// Depends on erma_pkg and the echo_ranging_moving_average RTL.
`timescale 1ns / 1ps

module echo_ranging_moving_average_tb;

    localparam int NUM_CHANNELS  = 3;
    localparam int WINDOW_LEN    = 8;
    localparam int US_PER_CM     = 58;
    localparam int SETTLE_CYCLES = 12;
    localparam int PHASE_WORDS   = 100;

    localparam logic [erma_pkg::CH_W-1:0] CH_CENTER = 2'd0;
    localparam logic [erma_pkg::CH_W-1:0] CH_LEFT   = 2'd1;
    localparam logic [erma_pkg::CH_W-1:0] CH_RIGHT  = 2'd2;
    localparam logic [erma_pkg::CH_W-1:0] CH_UNUSED = 2'd3;

    localparam logic [erma_pkg::TIMEOUT_W-1:0] TIMEOUT_MAX = '1;

    typedef struct packed {
        logic [erma_pkg::CH_W-1:0]   channel;
        logic [erma_pkg::DIST_W-1:0] distance;
        logic [erma_pkg::DIST_W-1:0] average;
        logic                        average_valid;
        logic                        timed_out;
    } range_result_t;

    class range_scoreboard;
        logic [erma_pkg::TIMEOUT_W-1:0] timeout_us;
        logic [erma_pkg::TIME_W-1:0]    pulse_start [NUM_CHANNELS];
        logic [erma_pkg::DIST_W-1:0]    samples [NUM_CHANNELS][WINDOW_LEN];
        int                             sample_count [NUM_CHANNELS];
        int                             oldest_slot [NUM_CHANNELS];
        int                             sample_sum [NUM_CHANNELS];
        logic [erma_pkg::DIST_W-1:0]    last_average [NUM_CHANNELS];
        range_result_t                  expected_ranges [$];
        int                             mismatches;

        function new();
            timeout_us = erma_pkg::TIMEOUT_RESET;
            mismatches = 0;
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                pulse_start[c]  = '0;
                sample_count[c] = 0;
                oldest_slot[c]  = 0;
                sample_sum[c]   = 0;
                last_average[c] = '0;
            end
        endfunction

        // Accepted input word: update channel state, queue a result on falling edges
        function void note_edge(logic [erma_pkg::CH_W-1:0] ch, logic kind,
                                logic [erma_pkg::TIME_W-1:0] stamp);
            range_result_t               r;
            logic [erma_pkg::TIME_W-1:0] len;
            logic [erma_pkg::DIST_W-1:0] d;
            int                          p;
            if (ch >= NUM_CHANNELS)
                return;
            if (kind == erma_pkg::EDGE_RISING) begin
                pulse_start[ch] = stamp;
                return;
            end
            len = stamp - pulse_start[ch];
            r = '0;
            r.channel = ch;
            if (len >= erma_pkg::TIME_W'(timeout_us)) begin
                r.timed_out = 1'b1;
                last_average[ch] = '0;
            end else begin
                d = erma_pkg::DIST_W'(len / US_PER_CM);
                r.distance = d;
                if (sample_count[ch] < WINDOW_LEN) begin
                    samples[ch][sample_count[ch]] = d;
                    sample_sum[ch] += d;
                    sample_count[ch]++;
                    oldest_slot[ch] = 0;
                end else begin
                    p = oldest_slot[ch];
                    sample_sum[ch] = sample_sum[ch] - samples[ch][p] + d;
                    samples[ch][p] = d;
                    oldest_slot[ch] = (p + 1) % WINDOW_LEN;
                    last_average[ch] = erma_pkg::DIST_W'(sample_sum[ch] / WINDOW_LEN);
                    r.average_valid = 1'b1;
                end
            end
            r.average = last_average[ch];
            expected_ranges.push_back(r);
        endfunction

        task report_mismatch(string what);
            $display("[%0t] MISMATCH: %s", $realtime, what);
            mismatches++;
        endtask

        task check_result(range_result_t got);
            range_result_t want;
            if (expected_ranges.size() == 0) begin
                report_mismatch($sformatf("unexpected result word %p", got));
                return;
            end
            want = expected_ranges.pop_front();
            if (got.channel != want.channel)
                report_mismatch($sformatf("channel got %0d want %0d",
                                          got.channel, want.channel));
            if (got.distance != want.distance)
                report_mismatch($sformatf("ch%0d distance got %0d want %0d",
                                          want.channel, got.distance, want.distance));
            if (got.average != want.average)
                report_mismatch($sformatf("ch%0d average got %0d want %0d",
                                          want.channel, got.average, want.average));
            if (got.average_valid != want.average_valid)
                report_mismatch($sformatf("ch%0d average_valid got %0b want %0b",
                                          want.channel, got.average_valid,
                                          want.average_valid));
            if (got.timed_out != want.timed_out)
                report_mismatch($sformatf("ch%0d timed_out got %0b want %0b",
                                          want.channel, got.timed_out, want.timed_out));
        endtask
    endclass

    logic                            aclk = 1'b0;
    logic                            aresetn;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [erma_pkg::TIMEOUT_W-1:0]  cfg_data;
    logic                            s_valid;
    logic                            s_ready;
    logic [erma_pkg::CH_W-1:0]       s_channel;
    logic                            s_edge_kind;
    logic [erma_pkg::TIME_W-1:0]     s_time_us;
    logic                            m_valid;
    logic                            m_ready;
    logic [erma_pkg::CH_W-1:0]       m_out_channel;
    logic [erma_pkg::DIST_W-1:0]     m_distance_cm;
    logic [erma_pkg::DIST_W-1:0]     m_average_cm;
    logic                            m_average_valid;
    logic                            m_timed_out;

    range_scoreboard             sb;
    bit                          calm_tail = 1'b0;
    bit                          rise_open [NUM_CHANNELS];
    logic [erma_pkg::TIME_W-1:0] rise_stamp [NUM_CHANNELS];

    echo_ranging_moving_average #(
        .CHANNELS    (NUM_CHANNELS),
        .WINDOW_SIZE (WINDOW_LEN)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_channel       (s_channel),
        .s_edge_kind     (s_edge_kind),
        .s_time_us       (s_time_us),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_channel   (m_out_channel),
        .m_distance_cm   (m_distance_cm),
        .m_average_cm    (m_average_cm),
        .m_average_valid (m_average_valid),
        .m_timed_out     (m_timed_out)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result('{m_out_channel, m_distance_cm, m_average_cm,
                              m_average_valid, m_timed_out});
    end

    // Result side: random stall bursts, always ready in the tail
    initial begin
        m_ready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (!calm_tail && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge aclk);
            end
        end
    end

    task automatic push_edge(input logic [erma_pkg::CH_W-1:0] ch, input logic kind,
                             input logic [erma_pkg::TIME_W-1:0] stamp);
        s_valid     <= 1'b1;
        s_channel   <= ch;
        s_edge_kind <= kind;
        s_time_us   <= stamp;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_edge(ch, kind, stamp);
    endtask

    // Rising-only words leave nothing to wait on, so give the queue time to empty too
    task automatic pause_until_drained();
        s_valid <= 1'b0;
        while (sb.expected_ranges.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_timeout(input logic [erma_pkg::TIMEOUT_W-1:0] limit);
        cfg_valid <= 1'b1;
        cfg_data  <= limit;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.timeout_us = limit;
        cfg_valid <= 1'b0;
    endtask

    // Mostly in-range pulses, short ones favored so averages stay meaningful
    function automatic logic [erma_pkg::TIME_W-1:0] pick_pulse_length(
            logic [erma_pkg::TIMEOUT_W-1:0] limit);
        int pick;
        pick = $urandom_range(0, 99);
        if (limit == 0 || pick >= 88) begin
            if (pick[0])
                return erma_pkg::TIME_W'(limit) + $urandom_range(0, 200);
            return $urandom;
        end
        if (pick < 55 && limit > 15000)
            return $urandom_range(0, 14999);
        return $urandom_range(0, limit - 1);
    endfunction

    task automatic run_random_phase(input int count);
        int                        sent;
        int                        pick;
        logic [erma_pkg::CH_W-1:0] ch;
        sent = 0;
        while (sent < count) begin
            if (!calm_tail && $urandom_range(0, 4) == 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge aclk);
            end
            pick = $urandom_range(0, 99);
            ch   = erma_pkg::CH_W'($urandom_range(0, NUM_CHANNELS - 1));
            if (pick < 85) begin
                // well-formed rise/fall pairs, interleaved across channels
                if (rise_open[ch]) begin
                    push_edge(ch, erma_pkg::EDGE_FALLING,
                              rise_stamp[ch] + pick_pulse_length(sb.timeout_us));
                    rise_open[ch] = 1'b0;
                end else begin
                    rise_stamp[ch] = $urandom;
                    push_edge(ch, erma_pkg::EDGE_RISING, rise_stamp[ch]);
                    rise_open[ch] = 1'b1;
                end
                sent++;
            end else if (pick < 93) begin
                push_edge(ch, erma_pkg::EDGE_FALLING, $urandom);
                sent++;
            end else if (pick < 97) begin
                // restarted pulse
                rise_stamp[ch] = $urandom;
                push_edge(ch, erma_pkg::EDGE_RISING, rise_stamp[ch]);
                rise_open[ch] = 1'b1;
                sent++;
            end else begin
                push_edge(CH_UNUSED, 1'($urandom_range(0, 1)), $urandom);
            end
        end
    endtask

    initial begin
        logic [erma_pkg::TIMEOUT_W-1:0] phase_limit [5];
        sb = new();
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            rise_open[c]  = 1'b0;
            rise_stamp[c] = '0;
        end
        aresetn     <= 1'b0;
        cfg_valid   <= 1'b0;
        cfg_data    <= '0;
        s_valid     <= 1'b0;
        s_channel   <= '0;
        s_edge_kind <= erma_pkg::EDGE_RISING;
        s_time_us   <= '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset timeout: fall with no rise, unused channel, stamp wrap, zero length,
        // just under and exactly at the limit, fall reusing an old rise
        push_edge(CH_CENTER, erma_pkg::EDGE_FALLING, 32'd1000);
        push_edge(CH_UNUSED, erma_pkg::EDGE_RISING, '1);
        push_edge(CH_UNUSED, erma_pkg::EDGE_FALLING, '1);
        push_edge(CH_LEFT, erma_pkg::EDGE_RISING, 32'hFFFF_FFF0);
        push_edge(CH_LEFT, erma_pkg::EDGE_FALLING, 32'h0000_0100);
        push_edge(CH_RIGHT, erma_pkg::EDGE_RISING, 32'd5);
        push_edge(CH_RIGHT, erma_pkg::EDGE_FALLING, 32'd5);
        push_edge(CH_RIGHT, erma_pkg::EDGE_RISING, 32'd0);
        push_edge(CH_RIGHT, erma_pkg::EDGE_FALLING, 32'd29999);
        push_edge(CH_RIGHT, erma_pkg::EDGE_RISING, 32'd100);
        push_edge(CH_RIGHT, erma_pkg::EDGE_FALLING, 32'd30100);
        push_edge(CH_RIGHT, erma_pkg::EDGE_FALLING, 32'd150);
        push_edge(CH_CENTER, erma_pkg::EDGE_FALLING, '1);

        // zero limit: everything times out
        pause_until_drained();
        write_timeout('0);
        push_edge(CH_CENTER, erma_pkg::EDGE_RISING, 32'd7);
        push_edge(CH_CENTER, erma_pkg::EDGE_FALLING, 32'd7);

        pause_until_drained();
        write_timeout(erma_pkg::TIMEOUT_W'(1));
        push_edge(CH_LEFT, erma_pkg::EDGE_RISING, 32'd40);
        push_edge(CH_LEFT, erma_pkg::EDGE_FALLING, 32'd40);
        push_edge(CH_LEFT, erma_pkg::EDGE_FALLING, 32'd41);

        // widest limit: distance wraps to its low byte
        pause_until_drained();
        write_timeout(TIMEOUT_MAX);
        push_edge(CH_RIGHT, erma_pkg::EDGE_RISING, 32'd0);
        push_edge(CH_RIGHT, erma_pkg::EDGE_FALLING, 32'h000F_FFFE);
        push_edge(CH_RIGHT, erma_pkg::EDGE_FALLING, 32'h000F_FFFF);

        phase_limit[0] = erma_pkg::TIMEOUT_RESET;
        phase_limit[1] = TIMEOUT_MAX;
        phase_limit[2] = erma_pkg::TIMEOUT_W'($urandom_range(60, 20000));
        phase_limit[3] = erma_pkg::TIMEOUT_W'(600);
        phase_limit[4] = erma_pkg::TIMEOUT_RESET;
        for (int i = 0; i < 5; i++) begin
            if (i == 4)
                calm_tail = 1'b1;
            pause_until_drained();
            write_timeout(phase_limit[i]);
            run_random_phase(PHASE_WORDS);
        end

        pause_until_drained();
        if (sb.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #4_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
